FILE: hw/rtl/crc64rb_pkg.sv
// Package: shared widths, register indexes, reset values and the byte update function.
package crc64rb_pkg;

  localparam int unsigned CrcWidth  = 64;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegPolynomial   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegInitialValue = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegInvertEnable = 2'd2;

  localparam logic [CrcWidth-1:0] PolyReset = 64'h9a6c9329ac4bc9b5;
  localparam logic [CrcWidth-1:0] InitReset = 64'h0;

  // Result item: CRC value plus final flag
  typedef struct packed {
    logic                crc_final;
    logic [CrcWidth-1:0] crc_value;
  } crc_result_t;

  localparam int unsigned ResultWidth = $bits(crc_result_t);

  // Fold one byte into a reflected CRC: xor into low bits, eight shift/xor levels
  function automatic logic [CrcWidth-1:0] crc_byte_update(
    input logic [CrcWidth-1:0]  crc_in,
    input logic [ByteWidth-1:0] data,
    input logic [CrcWidth-1:0]  poly
  );
    logic [CrcWidth-1:0] crc;
    crc = crc_in ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int i = 0; i < ByteWidth; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ poly) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

FILE: hw/rtl/crc64rb_out_buf.sv
// Two-entry output buffer (main register plus skid register) for result items.
module crc64rb_out_buf #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic             main_valid_q, main_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [Width-1:0] main_data_q, main_data_d;
  logic [Width-1:0] skid_data_q, skid_data_d;
  logic             push, pop;

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;
  assign push        = in_valid_i & in_ready_o;
  assign pop         = main_valid_q & out_ready_i;

  // Route each item to the main register, or park it in the skid register
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_data_d  = main_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_data_d  = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q || pop) begin
        main_data_d  = in_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_data_d  = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    main_data_q <= main_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

FILE: hw/rtl/crc64_reflected_bytewise.sv
// Top level: reflected CRC-64 engine, one message byte per item.
//
//  channel  | direction | tdata              | tuser       | tlast
//  s_axis   | in        | [7:0] data_byte    | first_byte  | last_byte
//  m_axis   | out       | [63:0] crc_value   | -           | crc_final
//  cfg      | in        | cfg_data_i [63:0], cfg_index_i [1:0] (0 poly, 1 init, 2 invert)
//
// One byte item per cycle while s_axis_tready is high; the eight shift/xor levels of the
// byte update are done in the accept cycle and the result is registered in the output
// buffer. Reset restores the default polynomial, zero initial value, no inversion and
// a zero running CRC. A two-entry output buffer keeps s_axis_tready high while
// one result waits; input stalls only when both entries are full.
// Configuration writes are always accepted.
module crc64_reflected_bytewise
  import crc64rb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ByteWidth-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] first_byte
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [CrcWidth-1:0]    m_axis_tdata,   // [63:0] crc_value
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CrcWidth-1:0]    cfg_data_i
);

  logic [CrcWidth-1:0] poly_q, init_q, running_q, running_d, crc_start, mask;
  logic                invert_q;
  logic                accept;
  crc_result_t         result, out_item;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid & s_axis_tready;
  assign mask        = {CrcWidth{invert_q}};

  // Pick the start value and fold in the byte
  assign crc_start        = s_axis_tuser ? (init_q ^ mask) : running_q;
  assign running_d        = crc_byte_update(crc_start, s_axis_tdata, poly_q);
  assign result.crc_value = running_d ^ mask;
  assign result.crc_final = s_axis_tlast;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q   <= PolyReset;
      init_q   <= InitReset;
      invert_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPolynomial:   poly_q   <= cfg_data_i;
        RegInitialValue: init_q   <= cfg_data_i;
        RegInvertEnable: invert_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance the running CRC on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
    end else if (accept) begin
      running_q <= running_d;
    end
  end

  crc64rb_out_buf #(
    .Width(ResultWidth)
  ) u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (result),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_item)
  );

  assign m_axis_tdata = out_item.crc_value;
  assign m_axis_tlast = out_item.crc_final;

endmodule

FILE: verif/crc64_result_checker.sv
`timescale 1ns / 1ps
// Checker: predicts the CRC-64 result of every byte item and compares it field by field.
module crc64_result_checker
  import crc64rb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [ByteWidth-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] first_byte
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [CrcWidth-1:0]    m_axis_tdata,   // [63:0] crc_value
  input  logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CrcWidth-1:0]    cfg_data_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  // Predicted register file and running remainder
  logic [CrcWidth-1:0] poly_q;
  logic [CrcWidth-1:0] init_q;
  logic                invert_q;
  logic [CrcWidth-1:0] crc_q;

  // Results still owed by the block, oldest first
  crc_result_t expected_crc_q[$];

  // Fold one byte into the remainder, least significant bit first
  function automatic logic [CrcWidth-1:0] fold_byte(
    input logic [CrcWidth-1:0]  crc,
    input logic [ByteWidth-1:0] b,
    input logic [CrcWidth-1:0]  poly
  );
    logic [CrcWidth-1:0] r;
    logic                lsb;
    r = crc;
    r[ByteWidth-1:0] = r[ByteWidth-1:0] ^ b;
    for (int n = 0; n < ByteWidth; n++) begin
      lsb = r[0];
      r = r >> 1;
      if (lsb) r = r ^ poly;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    crc_result_t         want;
    logic [CrcWidth-1:0] mask;
    logic [CrcWidth-1:0] start;
    int unsigned         errs;
    if (!rst_ni) begin
      poly_q = PolyReset;
      init_q = InitReset;
      invert_q = 1'b0;
      crc_q = '0;
      expected_crc_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      errs = 0;
      // Track register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegPolynomial:   poly_q = cfg_data_i;
          RegInitialValue: init_q = cfg_data_i;
          RegInvertEnable: invert_q = cfg_data_i[0];
          default: ;
        endcase
      end
      // Compare each result with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_crc_q.size() == 0) begin
          $error("unexpected result: crc_value %h crc_final %b", m_axis_tdata, m_axis_tlast);
          errs++;
        end else begin
          want = expected_crc_q.pop_front();
          if (want.crc_value !== m_axis_tdata) begin
            $error("crc_value mismatch: expected %h, actual %h", want.crc_value, m_axis_tdata);
            errs++;
          end
          if (want.crc_final !== m_axis_tlast) begin
            $error("crc_final mismatch: expected %b, actual %b", want.crc_final, m_axis_tlast);
            errs++;
          end
        end
      end
      // Predict the result of each accepted byte item
      if (s_axis_tvalid && s_axis_tready) begin
        mask = invert_q ? '1 : '0;
        start = s_axis_tuser ? (init_q ^ mask) : crc_q;
        crc_q = fold_byte(start, s_axis_tdata, poly_q);
        want.crc_value = crc_q ^ mask;
        want.crc_final = s_axis_tlast;
        expected_crc_q.push_back(want);
      end
      fail_count_o <= fail_count_o + errs;
      pending_o <= expected_crc_q.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top: drives byte items and register writes into the CRC-64 engine and reports.
module testbench;
  import crc64rb_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PhaseItems = 305;
  localparam int unsigned HoldCycles = 300;
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam logic [CrcWidth-1:0]    AllOnes   = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ByteWidth-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [CrcWidth-1:0]    m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CrcWidth-1:0]    cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  logic [31:0] rx_cycle = '0;

  crc64_reflected_bytewise u_top (.*);

  crc64_result_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: long hold-off on request, otherwise a rotating stall pattern
  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      case (rx_cycle[7:6])
        2'd0: m_axis_tready = 1'b1;
        2'd1: m_axis_tready = 1'($urandom_range(0, 1));
        2'd2: m_axis_tready = ($urandom_range(0, 4) == 0);
        default: m_axis_tready = (rx_cycle % 3 == 0);
      endcase
    end
  end

  function automatic logic [CrcWidth-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one byte item in bursts with random gaps, hold until accepted
  task automatic offer_byte(input logic [ByteWidth-1:0] b, input logic first, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tuser = first;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CrcWidth-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One register setting followed by random messages and noise
  task automatic run_phase(input int unsigned p);
    logic [CrcWidth-1:0] poly;
    logic [CrcWidth-1:0] init;
    logic [CrcWidth-1:0] inv_word;
    int unsigned         sent;
    int unsigned         len;
    bit                  mid_drained;
    inv_word = rand64();
    case (p)
      0: begin poly = PolyReset; init = InitReset; inv_word[0] = 1'b0; end
      1: begin poly = AllOnes; init = AllOnes; inv_word[0] = 1'b1; end
      2: begin poly = '0; init = rand64(); end
      default: begin poly = rand64(); init = rand64(); end
    endcase
    write_reg(RegPolynomial, poly);
    write_reg(RegInitialValue, init);
    write_reg(RegInvertEnable, inv_word);
    if (p == 4) write_reg(RegUnused, rand64());
    gaps_on = (p != 1);
    if (p == 2) hold_asked++;
    sent = 0;
    mid_drained = 1'b0;
    while (sent < PhaseItems) begin
      // Pause once mid-phase until the block has drained
      if (p == 3 && !mid_drained && sent >= PhaseItems / 2) begin
        wait_idle();
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        for (int k = 0; k < len; k++)
          offer_byte(8'($urandom_range(0, 255)), k == 0, k == len - 1);
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
      sent += len;
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Bytes without a start right after reset continue from a zero remainder
    offer_byte(8'h00, 1'b0, 1'b0);
    offer_byte(8'hff, 1'b0, 1'b1);
    // Standard check string "123456789" under reset settings
    for (int k = 0; k < 9; k++) offer_byte(8'h31 + 8'(k), k == 0, k == 8);
    // One-byte messages: start and end on the same item
    offer_byte(8'hff, 1'b1, 1'b1);
    offer_byte(8'h00, 1'b1, 1'b1);
    wait_idle();

    // Inverted mode with an all-ones initial value; upper bits of the option word set
    write_reg(RegInvertEnable, AllOnes);
    write_reg(RegInitialValue, AllOnes);
    write_reg(RegUnused, rand64());
    for (int k = 0; k < 9; k++) offer_byte(8'h31 + 8'(k), k == 0, k == 8);
    // Flip the option in the middle of a message
    offer_byte(8'ha5, 1'b1, 1'b0);
    wait_idle();
    write_reg(RegInvertEnable, AllOnes - 1);
    offer_byte(8'h5a, 1'b0, 1'b1);
    wait_idle();

    for (int unsigned p = 0; p < NumPhases; p++) run_phase(p);

    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
